FILE: design/qoi_pkg.sv
package qoi_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int HASH_W      = $clog2(TABLE_DEPTH);
  localparam int RUN_W       = 6;
  localparam int MAX_BYTES   = 6;
  localparam int CNT_W       = $clog2(MAX_BYTES + 1);

  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(62);

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hc0;
  localparam logic [7:0] OP_RGB   = 8'hfe;
  localparam logic [7:0] OP_RGBA  = 8'hff;

  // red in the lowest byte, as on the input bus
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } px_t;

  // one pixel after table look-up and run bookkeeping
  typedef struct packed {
    px_t              px;
    px_t              prev;
    logic             same;
    logic             run_flush;
    logic [RUN_W-1:0] run_code;
    logic [HASH_W-1:0] hash;
    px_t              entry;
  } stage_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
  } obytes_t;

  function automatic logic [HASH_W-1:0] colour_hash(input px_t p);
    logic [11:0] s;
    s = 12'(p.red) * 12'd3 + 12'(p.green) * 12'd5 + 12'(p.blue) * 12'd7
      + 12'(p.alpha) * 12'd11;
    return s[HASH_W-1:0];
  endfunction

endpackage

FILE: design/qoi_pixel_encoder_top.sv
// Streaming QOI pixel encoder. One RGBA pixel enters per item on in_* and the
// op bytes it causes leave one byte per item on out_*, out_tlast marking the
// last byte of each pixel; a repeated pixel that does not close a run gives no
// bytes at all. A pixel is accepted every clock as long as the bytes drain;
// a pixel gives one byte for run, index and diff ops, two for luma, four for
// RGB, five for RGBA, plus one when a run is flushed ahead of the op, all on
// the single output byte port; a pixel's bytes are loaded only as the last
// byte before them leaves. An accepted pixel is registered in the stage
// register, then in the output buffer. The 64-entry colour table is cleared at
// reset through per-entry valid flags, so no clearing pass is needed. cfg_wdata
// sets alpha_present (reset 1); with it low the previous alpha is reused. Write
// it only while the block is idle. File header and end marker are not produced.
module qoi_pixel_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,   // alpha_present
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  input  logic        in_tlast,    // final_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // out_byte[7:0]
  output logic        out_tlast    // item_done
);
  import qoi_pkg::*;

  stage_t  s1;
  logic    s1_valid;
  logic    s1_take;
  obytes_t ob;
  logic    buf_free;
  logic    load;

  // zero-byte pixels retire without touching the output buffer
  assign s1_take = s1_valid && (ob.cnt == '0 || buf_free);
  assign load    = s1_valid && ob.cnt != '0 && buf_free;

  qoi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .s1_take   (s1_take),
    .s1_valid  (s1_valid),
    .s1        (s1)
  );

  qoi_op_build u_build (
    .s1 (s1),
    .ob (ob)
  );

  qoi_out_buf u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .din        (ob),
    .buf_free   (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: design/qoi_front.sv
module qoi_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wen,
  input  logic             cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,
  input  logic             in_tlast,
  input  logic             s1_take,
  output logic             s1_valid,
  output qoi_pkg::stage_t  s1
);
  import qoi_pkg::*;

  logic              alpha_present_r;
  px_t               prev_r, prev_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  stage_t            s1_r;
  logic [TABLE_DEPTH-1:0] tab_valid_r;
  px_t               seen_r [TABLE_DEPTH];
  px_t               rd_data_r;
  logic              rd_valid_r;

  logic              accept;
  px_t               px;
  logic [HASH_W-1:0] hash;
  logic              same;
  logic [RUN_W-1:0]  run_inc;
  logic              flush;
  logic [RUN_W-1:0]  flush_code;

  assign in_tready = !s1_valid_r || s1_take;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    px       = px_t'(in_tdata);
    if (!alpha_present_r) begin
      px.alpha = prev_r.alpha;
    end
    hash       = colour_hash(px);
    same       = (px == prev_r);
    run_inc    = run_r + RUN_W'(1);
    flush      = 1'b0;
    flush_code = run_r;
    run_nxt    = run_r;
    prev_nxt   = prev_r;
    if (accept) begin
      prev_nxt = px;
      if (same) begin
        if (run_inc >= RUN_MAX || in_tlast) begin
          flush   = 1'b1;
          run_nxt = '0;
        end else begin
          run_nxt = run_inc;
        end
      end else begin
        flush      = (run_r != '0);
        flush_code = run_r - RUN_W'(1);
        run_nxt    = '0;
      end
    end
    s1_valid_nxt = accept ? 1'b1 : (s1_take ? 1'b0 : s1_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_present_r <= 1'b1;
      prev_r          <= '{alpha: 8'hff, blue: 8'h00, green: 8'h00, red: 8'h00};
      run_r           <= '0;
      s1_valid_r      <= 1'b0;
      tab_valid_r     <= '0;
    end else begin
      if (cfg_wen) begin
        alpha_present_r <= cfg_wdata;
      end
      prev_r     <= prev_nxt;
      run_r      <= run_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (accept && !same) begin
        tab_valid_r[hash] <= 1'b1;
      end
    end
  end

  // a differing pixel always lands in its slot; rewriting an index hit changes nothing
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r  <= seen_r[hash];
      rd_valid_r <= tab_valid_r[hash];
      if (!same) begin
        seen_r[hash] <= px;
      end
      s1_r.px        <= px;
      s1_r.prev      <= prev_r;
      s1_r.same      <= same;
      s1_r.run_flush <= flush;
      s1_r.run_code  <= flush_code;
      s1_r.hash      <= hash;
      s1_r.entry     <= '0;
    end
  end

  always_comb begin
    s1       = s1_r;
    s1.entry = rd_valid_r ? rd_data_r : '0;
  end

  assign s1_valid = s1_valid_r;

  a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
    run_r < RUN_MAX)
    else $error("run count reached flush limit without flushing");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_take |-> !in_tready)
    else $error("input taken while stage register is held");

  a_repeat_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    accept && same |=> $stable(tab_valid_r))
    else $error("table touched on a repeated pixel");

endmodule

FILE: design/qoi_op_build.sv
module qoi_op_build (
  input  qoi_pkg::stage_t  s1,
  output qoi_pkg::obytes_t ob
);
  import qoi_pkg::*;

  logic signed [7:0] dr, dg, db;
  logic signed [8:0] drg, dbg;
  logic [MAX_BYTES-2:0][7:0] op;
  logic [CNT_W-1:0] op_n;
  logic [7:0] run_byte;
  logic hit;
  logic [5:0] luma_g;
  logic [3:0] luma_r, luma_b;

  always_comb begin
    dr     = signed'(s1.px.red   - s1.prev.red);
    dg     = signed'(s1.px.green - s1.prev.green);
    db     = signed'(s1.px.blue  - s1.prev.blue);
    drg    = 9'(signed'({dr[7], dr}) - signed'({dg[7], dg}));
    dbg    = 9'(signed'({db[7], db}) - signed'({dg[7], dg}));
    luma_g = dg[5:0] + 6'd32;
    luma_r = drg[3:0] + 4'd8;
    luma_b = dbg[3:0] + 4'd8;
    hit    = (s1.entry == s1.px);
    run_byte = OP_RUN | {2'b00, s1.run_code};

    op   = '0;
    op_n = '0;
    if (hit) begin
      op[0] = OP_INDEX | {2'b00, s1.hash};
      op_n  = CNT_W'(1);
    end else if (s1.px.alpha == s1.prev.alpha) begin
      if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
        op[0] = OP_DIFF | {2'b00, dr[1:0] + 2'd2, dg[1:0] + 2'd2, db[1:0] + 2'd2};
        op_n  = CNT_W'(1);
      end else if (dg >= -32 && dg <= 31 && drg >= -8 && drg <= 7 &&
                   dbg >= -8 && dbg <= 7) begin
        op[0] = OP_LUMA | {2'b00, luma_g};
        op[1] = {luma_r, luma_b};
        op_n  = CNT_W'(2);
      end else begin
        op[0] = OP_RGB;
        op[1] = s1.px.red;
        op[2] = s1.px.green;
        op[3] = s1.px.blue;
        op_n  = CNT_W'(4);
      end
    end else begin
      op[0] = OP_RGBA;
      op[1] = s1.px.red;
      op[2] = s1.px.green;
      op[3] = s1.px.blue;
      op[4] = s1.px.alpha;
      op_n  = CNT_W'(5);
    end

    ob = '0;
    if (s1.same) begin
      ob.bytes[0] = run_byte;
      ob.cnt      = s1.run_flush ? CNT_W'(1) : '0;
    end else if (s1.run_flush) begin
      ob.bytes[0]             = run_byte;
      ob.bytes[MAX_BYTES-1:1] = op;
      ob.cnt                  = op_n + CNT_W'(1);
    end else begin
      ob.bytes[MAX_BYTES-2:0] = op;
      ob.cnt                  = op_n;
    end
  end

endmodule

FILE: design/qoi_out_buf.sv
module qoi_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  qoi_pkg::obytes_t  din,
  output logic              buf_free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic              out_tlast
);
  import qoi_pkg::*;

  logic [MAX_BYTES-1:0][7:0] bytes_r, bytes_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      pop;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = bytes_r[0];
  assign out_tlast  = (cnt_r == CNT_W'(1));
  assign pop        = out_tvalid && out_tready;
  assign buf_free   = !out_tvalid || (pop && out_tlast);

  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      bytes_nxt = din.bytes;
      cnt_nxt   = din.cnt;
    end else if (pop) begin
      bytes_nxt = {8'h00, bytes_r[MAX_BYTES-1:1]};
      cnt_nxt   = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> buf_free)
    else $error("pending bytes overwritten");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BYTES))
    else $error("byte count out of range");

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> din.cnt != '0)
    else $error("empty byte group loaded");

endmodule

FILE: tb/sv/tb_qoi_pixel_encoder_top.sv
`timescale 1ns / 1ps

module tb_qoi_pixel_encoder_top;
  import qoi_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] value;
    logic       done;
  } exp_byte_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wen = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  // encoder state as the testbench sees it
  logic        alpha_on;
  px_t         prev_px;
  int          run_len;
  px_t         seen_tbl [TABLE_DEPTH];

  exp_byte_t   pending_bytes [$];
  exp_byte_t   head;
  px_t         recent_px [$];
  int          repeat_left = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_req = 1'b0;
  int          errors = 0;
  int          stuck_cycles = 0;

  qoi_pixel_encoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_model();
    alpha_on = 1'b1;
    prev_px  = {8'd255, 8'd0, 8'd0, 8'd0};
    run_len  = 0;
    foreach (seen_tbl[i]) seen_tbl[i] = '0;
  endfunction

  function automatic int sdiff8(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = a - b;
    return int'($signed(d));
  endfunction

  function automatic px_t mk_px(input int r, input int g, input int b, input int a);
    return {8'(a), 8'(b), 8'(g), 8'(r)};
  endfunction

  // op bytes one accepted pixel produces; updates the encoder state
  function automatic void encode_pixel(input px_t raw, input logic last);
    px_t        p;
    logic [7:0] ob [$];
    exp_byte_t  eb;
    int         h;
    int         dr;
    int         dg;
    int         db;
    int         drg;
    int         dbg;
    p = raw;
    if (!alpha_on) p.alpha = prev_px.alpha;
    if (p == prev_px) begin
      run_len++;
      if (run_len >= int'(RUN_MAX) || last) begin
        ob.push_back(OP_RUN | 8'(run_len - 1));
        run_len = 0;
      end
    end else begin
      if (run_len > 0) begin
        ob.push_back(OP_RUN | 8'(run_len - 1));
        run_len = 0;
      end
      h = (int'(p.red) * 3 + int'(p.green) * 5 + int'(p.blue) * 7 + int'(p.alpha) * 11)
          % TABLE_DEPTH;
      if (seen_tbl[h] == p) begin
        ob.push_back(OP_INDEX | 8'(h));
      end else begin
        seen_tbl[h] = p;
        if (p.alpha == prev_px.alpha) begin
          dr  = sdiff8(p.red, prev_px.red);
          dg  = sdiff8(p.green, prev_px.green);
          db  = sdiff8(p.blue, prev_px.blue);
          drg = dr - dg;
          dbg = db - dg;
          if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
            ob.push_back(OP_DIFF | {2'b00, 2'(dr + 2), 2'(dg + 2), 2'(db + 2)});
          end else if (dg >= -32 && dg <= 31 && drg >= -8 && drg <= 7 &&
                       dbg >= -8 && dbg <= 7) begin
            ob.push_back(OP_LUMA | 8'(dg + 32));
            ob.push_back({4'(drg + 8), 4'(dbg + 8)});
          end else begin
            ob.push_back(OP_RGB);
            ob.push_back(p.red);
            ob.push_back(p.green);
            ob.push_back(p.blue);
          end
        end else begin
          ob.push_back(OP_RGBA);
          ob.push_back(p.red);
          ob.push_back(p.green);
          ob.push_back(p.blue);
          ob.push_back(p.alpha);
        end
      end
    end
    prev_px = p;
    for (int i = 0; i < ob.size(); i++) begin
      eb.value = ob[i];
      eb.done  = (i == ob.size() - 1);
      pending_bytes.push_back(eb);
    end
  endfunction

  task automatic send_pixel(input px_t p, input logic last);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    encode_pixel(p, last);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic set_alpha_present(input logic v);
    wait_drain();
    // a repeated pixel leaves no byte behind, so give the pipe time to empty
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen  <= 1'b0;
    alpha_on = v;
  endtask

  // mostly image-like pixels: runs, small steps, luma steps, revisited colours
  task automatic next_pixel(output px_t p);
    int m;
    int dr;
    int dg;
    int db;
    p = prev_px;
    if (repeat_left > 0) begin
      repeat_left--;
    end else begin
      m = $urandom_range(99);
      if (m < 20) begin
        repeat_left = ($urandom_range(29) == 0) ? $urandom_range(70, 55) : $urandom_range(3);
      end else if (m < 40) begin
        p.red   = prev_px.red + 8'($urandom_range(3)) - 8'd2;
        p.green = prev_px.green + 8'($urandom_range(3)) - 8'd2;
        p.blue  = prev_px.blue + 8'($urandom_range(3)) - 8'd2;
      end else if (m < 58) begin
        dg = int'($urandom_range(63)) - 32;
        dr = dg + int'($urandom_range(15)) - 8;
        db = dg + int'($urandom_range(15)) - 8;
        p.red   = prev_px.red + 8'(dr);
        p.green = prev_px.green + 8'(dg);
        p.blue  = prev_px.blue + 8'(db);
      end else if (m < 72 && recent_px.size() > 0) begin
        p = recent_px[$urandom_range(recent_px.size() - 1)];
      end else if (m < 86) begin
        p.red   = 8'($urandom);
        p.green = 8'($urandom);
        p.blue  = 8'($urandom);
      end else begin
        p = px_t'($urandom);
      end
      recent_px.push_back(p);
      if (recent_px.size() > 16) void'(recent_px.pop_front());
    end
    if (!alpha_on) p.alpha = 8'($urandom);
  endtask

  task automatic random_pixels(input int n);
    px_t p;
    repeat (n) begin
      next_pixel(p);
      send_pixel(p, $urandom_range(39) == 0);
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("byte %02h (last %b) with nothing expected",
                                  out_tdata, out_tlast));
      end else begin
        head = pending_bytes.pop_front();
        if (out_tdata !== head.value)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_tdata, head.value));
        if (out_tlast !== head.done)
          report_mismatch($sformatf("item_done %b, expected %b (byte %02h)",
                                    out_tlast, head.done, head.value));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_pixel(mk_px(0, 0, 0, 255), 1'b0);       // same as reset pixel: run, no bytes
    send_pixel(mk_px(0, 0, 0, 255), 1'b0);
    send_pixel(mk_px(1, 255, 254, 255), 1'b0);   // run flush then diff
    send_pixel(mk_px(21, 20, 25, 255), 1'b0);    // luma
    send_pixel(mk_px(200, 10, 90, 255), 1'b0);   // rgb
    send_pixel(mk_px(200, 10, 90, 17), 1'b0);    // rgba
    send_pixel(mk_px(21, 20, 25, 255), 1'b0);    // index
    send_pixel(mk_px(255, 255, 255, 255), 1'b0);
    send_pixel(mk_px(0, 0, 0, 0), 1'b0);         // hits the cleared table entry
    send_pixel(mk_px(255, 255, 255, 0), 1'b0);   // diff across the wrap
    send_pixel(mk_px(0, 0, 0, 0), 1'b0);
    send_pixel(mk_px(0, 0, 0, 0), 1'b0);
    send_pixel(mk_px(0, 0, 0, 0), 1'b1);         // final pixel closes the run
    send_pixel(mk_px(5, 5, 5, 5), 1'b1);         // final with no run pending
    send_pixel(mk_px(5, 5, 5, 5), 1'b1);         // run of one flushed
    send_pixel(mk_px(229, 229, 229, 5), 1'b0);   // luma, green step -32
    send_pixel(mk_px(4, 4, 4, 5), 1'b0);         // luma, green step +31 via wrap
    send_pixel(mk_px(12, 4, 252, 5), 1'b0);
    send_pixel(mk_px(11, 4, 253, 5), 1'b0);
    send_pixel(mk_px(3, 4, 5, 5), 1'b0);
  endtask

  task automatic test_alpha_absent();
    set_alpha_present(1'b0);
    send_idle_pct = 0;
    stall_pct = 0;
    send_pixel(mk_px(3, 4, 5, 0), 1'b0);         // alpha field ignored: still a repeat
    send_pixel(mk_px(3, 4, 5, 255), 1'b0);
    send_pixel(mk_px(90, 4, 5, 0), 1'b0);
    random_pixels(32);
    set_alpha_present(1'b1);
  endtask

  task automatic test_run_limit();
    px_t p;
    send_idle_pct = 0;
    stall_pct = 20;
    p = px_t'($urandom);
    // 63 repeats: the run closes at 62 and one more pixel starts another
    repeat (64) send_pixel(p, 1'b0);
    p.red = p.red ^ 8'h80;
    send_pixel(p, 1'b0);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    repeat (30) send_pixel(px_t'($urandom), $urandom_range(9) == 0);
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;
    stall_pct = 0;
    random_pixels(70);
    send_idle_pct = 55;
    stall_pct = 0;
    random_pixels(55);
    send_idle_pct = 0;
    stall_pct = 55;
    random_pixels(55);
    send_idle_pct = 19;
    stall_pct = 19;
    random_pixels(25);
    wait_drain();
    random_pixels(20);
  endtask

  initial begin
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_alpha_absent();
    test_run_limit();
    test_backpressure();
    test_idle_phases();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: qoi_pixel_encoder_top.f
design/qoi_pkg.sv
design/qoi_front.sv
design/qoi_op_build.sv
design/qoi_out_buf.sv
design/qoi_pixel_encoder_top.sv
tb/sv/tb_qoi_pixel_encoder_top.sv
